### hw/rtl/fpid_pkg.sv
// Shared types and constants for the floating-point instruction decoder.
// No dependencies; used by every module of the block.
package fpid_pkg;

  // Field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned OpIdW  = 6;
  localparam int unsigned RegW   = 5;
  localparam int unsigned RmW    = 3;
  localparam int unsigned LenW   = 3;
  localparam int unsigned OpcW   = 7;
  localparam int unsigned F7W    = 7;

  // Instruction lengths in bytes
  localparam logic [LenW-1:0] LEN_SHORT = 3'd2;
  localparam logic [LenW-1:0] LEN_WORD  = 3'd4;

  // Status codes
  localparam logic STAT_LOCAL   = 1'b0;
  localparam logic STAT_FOREIGN = 1'b1;

  // Major opcodes decoded here
  localparam logic [OpcW-1:0] OPC_MADD   = 7'h43;
  localparam logic [OpcW-1:0] OPC_MSUB   = 7'h47;
  localparam logic [OpcW-1:0] OPC_NMSUB  = 7'h4B;
  localparam logic [OpcW-1:0] OPC_NMADD  = 7'h4F;
  localparam logic [OpcW-1:0] OPC_OP_FP  = 7'h53;

  // Major opcodes handed to other decoders
  localparam logic [OpcW-1:0] OPC_LOAD      = 7'h03;
  localparam logic [OpcW-1:0] OPC_LOAD_FP   = 7'h07;
  localparam logic [OpcW-1:0] OPC_MISC_MEM  = 7'h0F;
  localparam logic [OpcW-1:0] OPC_OP_IMM    = 7'h13;
  localparam logic [OpcW-1:0] OPC_AUIPC     = 7'h17;
  localparam logic [OpcW-1:0] OPC_OP_IMM_32 = 7'h1B;
  localparam logic [OpcW-1:0] OPC_STORE     = 7'h23;
  localparam logic [OpcW-1:0] OPC_STORE_FP  = 7'h27;
  localparam logic [OpcW-1:0] OPC_AMO       = 7'h2F;
  localparam logic [OpcW-1:0] OPC_OP        = 7'h33;
  localparam logic [OpcW-1:0] OPC_LUI       = 7'h37;
  localparam logic [OpcW-1:0] OPC_OP_32     = 7'h3B;
  localparam logic [OpcW-1:0] OPC_BRANCH    = 7'h63;
  localparam logic [OpcW-1:0] OPC_JALR      = 7'h67;
  localparam logic [OpcW-1:0] OPC_JAL       = 7'h6F;
  localparam logic [OpcW-1:0] OPC_SYSTEM    = 7'h73;

  // OP-FP funct7 codes
  localparam logic [F7W-1:0] F7_FADD_S   = 7'h00;
  localparam logic [F7W-1:0] F7_FADD_D   = 7'h01;
  localparam logic [F7W-1:0] F7_FSUB_S   = 7'h04;
  localparam logic [F7W-1:0] F7_FSUB_D   = 7'h05;
  localparam logic [F7W-1:0] F7_FMUL_S   = 7'h08;
  localparam logic [F7W-1:0] F7_FMUL_D   = 7'h09;
  localparam logic [F7W-1:0] F7_FDIV_S   = 7'h0C;
  localparam logic [F7W-1:0] F7_FDIV_D   = 7'h0D;
  localparam logic [F7W-1:0] F7_FSQRT_S  = 7'h2C;
  localparam logic [F7W-1:0] F7_FSQRT_D  = 7'h2D;
  localparam logic [F7W-1:0] F7_FSGNJ_S  = 7'h10;
  localparam logic [F7W-1:0] F7_FSGNJ_D  = 7'h11;
  localparam logic [F7W-1:0] F7_FMINMAX_S = 7'h14;
  localparam logic [F7W-1:0] F7_FMINMAX_D = 7'h15;
  localparam logic [F7W-1:0] F7_FCVT_S_D = 7'h20;
  localparam logic [F7W-1:0] F7_FCVT_D_S = 7'h21;
  localparam logic [F7W-1:0] F7_FCVT_X_S = 7'h60;
  localparam logic [F7W-1:0] F7_FCVT_X_D = 7'h61;
  localparam logic [F7W-1:0] F7_FMVCLS_S = 7'h70;
  localparam logic [F7W-1:0] F7_FMVCLS_D = 7'h71;
  localparam logic [F7W-1:0] F7_FCMP_S   = 7'h50;
  localparam logic [F7W-1:0] F7_FCMP_D   = 7'h51;
  localparam logic [F7W-1:0] F7_FCVT_S_X = 7'h68;
  localparam logic [F7W-1:0] F7_FCVT_D_X = 7'h69;
  localparam logic [F7W-1:0] F7_FMV_W_X  = 7'h78;
  localparam logic [F7W-1:0] F7_FMV_D_X  = 7'h79;

  // Operation numbers (first member of each group)
  localparam logic [OpIdW-1:0] OP_ILLEGAL  = 6'd0;
  localparam logic [OpIdW-1:0] OP_FMADD_S  = 6'd1;
  localparam logic [OpIdW-1:0] OP_FADD_S   = 6'd9;
  localparam logic [OpIdW-1:0] OP_FADD_D   = 6'd10;
  localparam logic [OpIdW-1:0] OP_FSUB_S   = 6'd11;
  localparam logic [OpIdW-1:0] OP_FSUB_D   = 6'd12;
  localparam logic [OpIdW-1:0] OP_FMUL_S   = 6'd13;
  localparam logic [OpIdW-1:0] OP_FMUL_D   = 6'd14;
  localparam logic [OpIdW-1:0] OP_FDIV_S   = 6'd15;
  localparam logic [OpIdW-1:0] OP_FDIV_D   = 6'd16;
  localparam logic [OpIdW-1:0] OP_FSQRT_S  = 6'd17;
  localparam logic [OpIdW-1:0] OP_FSQRT_D  = 6'd18;
  localparam logic [OpIdW-1:0] OP_FSGNJ_S  = 6'd19;
  localparam logic [OpIdW-1:0] OP_FSGNJ_D  = 6'd22;
  localparam logic [OpIdW-1:0] OP_FMIN_S   = 6'd25;
  localparam logic [OpIdW-1:0] OP_FMIN_D   = 6'd27;
  localparam logic [OpIdW-1:0] OP_FCVT_S_D = 6'd29;
  localparam logic [OpIdW-1:0] OP_FCVT_D_S = 6'd30;
  localparam logic [OpIdW-1:0] OP_FCVT_W_S = 6'd31;
  localparam logic [OpIdW-1:0] OP_FCVT_W_D = 6'd35;
  localparam logic [OpIdW-1:0] OP_FMV_X_W  = 6'd39;
  localparam logic [OpIdW-1:0] OP_FMV_X_D  = 6'd41;
  localparam logic [OpIdW-1:0] OP_FLE_S    = 6'd43;
  localparam logic [OpIdW-1:0] OP_FLE_D    = 6'd46;
  localparam logic [OpIdW-1:0] OP_FCVT_S_W = 6'd49;
  localparam logic [OpIdW-1:0] OP_FCVT_D_W = 6'd53;
  localparam logic [OpIdW-1:0] OP_FMV_W_X  = 6'd57;
  localparam logic [OpIdW-1:0] OP_FMV_D_X  = 6'd58;

  // One decoded result beat
  typedef struct packed {
    logic              status;
    logic [OpIdW-1:0]  op_id;
    logic [RegW-1:0]   dest_reg;
    logic [RegW-1:0]   src1_reg;
    logic [RegW-1:0]   src2_reg;
    logic [RegW-1:0]   src3_reg;
    logic [RmW-1:0]    round_mode;
    logic [LenW-1:0]   length_bytes;
  } fpid_result_t;

endpackage

### hw/rtl/fpid_opfp_dec.sv
// OP-FP sub-decoder: maps funct7, rs2 and funct3 to an operation number.
// Depends on fpid_pkg.
module fpid_opfp_dec (
  input  logic [fpid_pkg::F7W-1:0]   funct7,
  input  logic [fpid_pkg::RegW-1:0]  rs2,
  input  logic [fpid_pkg::RmW-1:0]   funct3,
  output logic [fpid_pkg::OpIdW-1:0] op_id
);

  logic [fpid_pkg::OpIdW-1:0] f3_ext;
  logic [fpid_pkg::OpIdW-1:0] rs2_ext;
  logic                       rs2_zero;
  logic                       rs2_low;

  assign f3_ext   = {{(fpid_pkg::OpIdW - fpid_pkg::RmW){1'b0}}, funct3};
  assign rs2_ext  = {1'b0, rs2};
  assign rs2_zero = (rs2 == '0);
  assign rs2_low  = (rs2 <= 5'd3);

  // funct7 selects the group; rs2/funct3 refine or qualify it
  always_comb begin
    op_id = fpid_pkg::OP_ILLEGAL;
    case (funct7)
      fpid_pkg::F7_FADD_S:  op_id = fpid_pkg::OP_FADD_S;
      fpid_pkg::F7_FADD_D:  op_id = fpid_pkg::OP_FADD_D;
      fpid_pkg::F7_FSUB_S:  op_id = fpid_pkg::OP_FSUB_S;
      fpid_pkg::F7_FSUB_D:  op_id = fpid_pkg::OP_FSUB_D;
      fpid_pkg::F7_FMUL_S:  op_id = fpid_pkg::OP_FMUL_S;
      fpid_pkg::F7_FMUL_D:  op_id = fpid_pkg::OP_FMUL_D;
      fpid_pkg::F7_FDIV_S:  op_id = fpid_pkg::OP_FDIV_S;
      fpid_pkg::F7_FDIV_D:  op_id = fpid_pkg::OP_FDIV_D;
      fpid_pkg::F7_FSQRT_S: if (rs2_zero) op_id = fpid_pkg::OP_FSQRT_S;
      fpid_pkg::F7_FSQRT_D: if (rs2_zero) op_id = fpid_pkg::OP_FSQRT_D;
      fpid_pkg::F7_FSGNJ_S: begin
        if (funct3 <= 3'd2) op_id = fpid_pkg::OP_FSGNJ_S + f3_ext;
      end
      fpid_pkg::F7_FSGNJ_D: begin
        if (funct3 <= 3'd2) op_id = fpid_pkg::OP_FSGNJ_D + f3_ext;
      end
      fpid_pkg::F7_FMINMAX_S: begin
        if (funct3 <= 3'd1) op_id = fpid_pkg::OP_FMIN_S + f3_ext;
      end
      fpid_pkg::F7_FMINMAX_D: begin
        if (funct3 <= 3'd1) op_id = fpid_pkg::OP_FMIN_D + f3_ext;
      end
      fpid_pkg::F7_FCVT_S_D: if (rs2 == 5'd1) op_id = fpid_pkg::OP_FCVT_S_D;
      fpid_pkg::F7_FCVT_D_S: if (rs2_zero) op_id = fpid_pkg::OP_FCVT_D_S;
      fpid_pkg::F7_FCVT_X_S: if (rs2_low) op_id = fpid_pkg::OP_FCVT_W_S + rs2_ext;
      fpid_pkg::F7_FCVT_X_D: if (rs2_low) op_id = fpid_pkg::OP_FCVT_W_D + rs2_ext;
      fpid_pkg::F7_FMVCLS_S: begin
        if (rs2_zero && funct3 <= 3'd1) op_id = fpid_pkg::OP_FMV_X_W + f3_ext;
      end
      fpid_pkg::F7_FMVCLS_D: begin
        if (rs2_zero && funct3 <= 3'd1) op_id = fpid_pkg::OP_FMV_X_D + f3_ext;
      end
      fpid_pkg::F7_FCMP_S: if (funct3 <= 3'd2) op_id = fpid_pkg::OP_FLE_S + f3_ext;
      fpid_pkg::F7_FCMP_D: if (funct3 <= 3'd2) op_id = fpid_pkg::OP_FLE_D + f3_ext;
      fpid_pkg::F7_FCVT_S_X: if (rs2_low) op_id = fpid_pkg::OP_FCVT_S_W + rs2_ext;
      fpid_pkg::F7_FCVT_D_X: if (rs2_low) op_id = fpid_pkg::OP_FCVT_D_W + rs2_ext;
      fpid_pkg::F7_FMV_W_X: begin
        if (rs2_zero && funct3 == 3'd0) op_id = fpid_pkg::OP_FMV_W_X;
      end
      fpid_pkg::F7_FMV_D_X: begin
        if (rs2_zero && funct3 == 3'd0) op_id = fpid_pkg::OP_FMV_D_X;
      end
      default: op_id = fpid_pkg::OP_ILLEGAL;
    endcase
  end

endmodule

### hw/rtl/fpid_decode.sv
// Full word decode: length class, foreign opcodes, fused forms and OP-FP.
// Depends on fpid_pkg and fpid_opfp_dec.
module fpid_decode (
  input  logic [fpid_pkg::WordW-1:0] word,
  output fpid_pkg::fpid_result_t     res
);

  logic [fpid_pkg::OpcW-1:0]  opc;
  logic [fpid_pkg::F7W-1:0]   f7;
  logic [fpid_pkg::RmW-1:0]   f3;
  logic [fpid_pkg::RegW-1:0]  rs2;
  logic [fpid_pkg::OpIdW-1:0] opfp_op;
  logic                       foreign;

  assign opc = word[6:0];
  assign f7  = word[31:25];
  assign f3  = word[14:12];
  assign rs2 = word[24:20];

  fpid_opfp_dec u_opfp (
    .funct7 (f7),
    .rs2    (rs2),
    .funct3 (f3),
    .op_id  (opfp_op)
  );

  // Opcodes owned by the integer/memory/branch/system decoders
  always_comb begin
    case (opc)
      fpid_pkg::OPC_LOAD,   fpid_pkg::OPC_LOAD_FP,   fpid_pkg::OPC_MISC_MEM,
      fpid_pkg::OPC_OP_IMM, fpid_pkg::OPC_AUIPC,     fpid_pkg::OPC_OP_IMM_32,
      fpid_pkg::OPC_STORE,  fpid_pkg::OPC_STORE_FP,  fpid_pkg::OPC_AMO,
      fpid_pkg::OPC_OP,     fpid_pkg::OPC_LUI,       fpid_pkg::OPC_OP_32,
      fpid_pkg::OPC_BRANCH, fpid_pkg::OPC_JALR,      fpid_pkg::OPC_JAL,
      fpid_pkg::OPC_SYSTEM: foreign = 1'b1;
      default:              foreign = 1'b0;
    endcase
  end

  // Result assembly
  always_comb begin
    res              = '0;
    res.status       = fpid_pkg::STAT_LOCAL;
    res.op_id        = fpid_pkg::OP_ILLEGAL;
    res.length_bytes = fpid_pkg::LEN_WORD;
    if (word[1:0] != 2'b11) begin
      // compressed
      res.status       = fpid_pkg::STAT_FOREIGN;
      res.length_bytes = fpid_pkg::LEN_SHORT;
    end else if (word[4:0] == 5'b11111) begin
      // longer-than-32-bit encoding: illegal here
      res.length_bytes = fpid_pkg::LEN_SHORT;
    end else if (foreign) begin
      res.status = fpid_pkg::STAT_FOREIGN;
    end else begin
      res.dest_reg = word[11:7];
      res.src1_reg = word[19:15];
      res.src2_reg = rs2;
      case (opc)
        fpid_pkg::OPC_MADD, fpid_pkg::OPC_MSUB,
        fpid_pkg::OPC_NMSUB, fpid_pkg::OPC_NMADD: begin
          // fmt must be single or double; opcode bits 3:2 pick the flavor
          if (!f7[1]) begin
            res.op_id      = fpid_pkg::OP_FMADD_S + {3'b000, opc[3:2], f7[0]};
            res.src3_reg   = f7[6:2];
            res.round_mode = f3;
          end
        end
        fpid_pkg::OPC_OP_FP: begin
          res.op_id = opfp_op;
          if (opfp_op != fpid_pkg::OP_ILLEGAL) res.round_mode = f3;
        end
        default: res.op_id = fpid_pkg::OP_ILLEGAL;
      endcase
    end
  end

endmodule

### hw/rtl/fp_instruction_decoder.sv
// Top level of the floating-point instruction decoder: input register,
// decode logic and result register. Depends on fpid_pkg and fpid_decode.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | instr_word
//   out     | out_valid,out_stall| status, op_id, dest_reg, src1_reg,
//           |                    | src2_reg, src3_reg, round_mode, length_bytes
//
// One beat per cycle while the output is not stalled; an accepted word passes
// through the input register, then is decoded into the result register.
// Synchronous active-high rst empties both stages.
// A stalled output holds its beat; a word still enters while the input stage
// is empty or moving into the result register.
module fp_instruction_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpid_pkg::WordW-1:0]        instr_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic [fpid_pkg::OpIdW-1:0]        op_id,
  output logic [fpid_pkg::RegW-1:0]         dest_reg,
  output logic [fpid_pkg::RegW-1:0]         src1_reg,
  output logic [fpid_pkg::RegW-1:0]         src2_reg,
  output logic [fpid_pkg::RegW-1:0]         src3_reg,
  output logic [fpid_pkg::RmW-1:0]          round_mode,
  output logic [fpid_pkg::LenW-1:0]         length_bytes
);

  logic                          word_valid;
  logic [fpid_pkg::WordW-1:0]    word_q;
  logic                          res_valid;
  fpid_pkg::fpid_result_t        res_q;
  fpid_pkg::fpid_result_t        dec_res;
  logic                          res_move;
  logic                          in_take;

  // Stage advance control
  assign res_move = !res_valid || !out_stall;
  assign in_stall = word_valid && !res_move;
  assign in_take  = in_valid && !in_stall;

  fpid_decode u_dec (
    .word (word_q),
    .res  (dec_res)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (!in_stall) word_valid <= in_valid;
      if (res_move)  res_valid  <= word_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take)               word_q <= instr_word;
    if (res_move && word_valid) res_q <= dec_res;
  end

  assign out_valid    = res_valid;
  assign status       = res_q.status;
  assign op_id        = res_q.op_id;
  assign dest_reg     = res_q.dest_reg;
  assign src1_reg     = res_q.src1_reg;
  assign src2_reg     = res_q.src2_reg;
  assign src3_reg     = res_q.src3_reg;
  assign round_mode   = res_q.round_mode;
  assign length_bytes = res_q.length_bytes;

endmodule

### hw/rtl/fpid_checker.sv
// Port-level checks for fp_instruction_decoder, bound onto the top level.
// Depends on fpid_pkg.
module fpid_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        status,
  input logic [fpid_pkg::OpIdW-1:0]  op_id,
  input logic [fpid_pkg::RegW-1:0]   dest_reg,
  input logic [fpid_pkg::RegW-1:0]   src1_reg,
  input logic [fpid_pkg::RegW-1:0]   src2_reg,
  input logic [fpid_pkg::RegW-1:0]   src3_reg,
  input logic [fpid_pkg::RmW-1:0]    round_mode,
  input logic [fpid_pkg::LenW-1:0]   length_bytes
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(op_id) && $stable(status)
      && $stable(length_bytes))
    else $error("stalled result beat changed");

  // Handed-off words carry no operation and no rounding mode
  a_foreign: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == fpid_pkg::STAT_FOREIGN |->
      op_id == fpid_pkg::OP_ILLEGAL && round_mode == '0 && src3_reg == '0)
    else $error("foreign beat carries decode fields");

  // Short lengths never decode to registers
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_bytes == fpid_pkg::LEN_SHORT |->
      op_id == fpid_pkg::OP_ILLEGAL && dest_reg == '0 && src1_reg == '0
      && src2_reg == '0)
    else $error("short word decoded fields");

  // Only fused forms use the third source
  a_rs3: assert property (@(posedge clk) disable iff (rst)
    out_valid && src3_reg != '0 |->
      op_id >= fpid_pkg::OP_FMADD_S && op_id < fpid_pkg::OP_FADD_S)
    else $error("third source on non-fused form");

  // A legal operation is in range and comes from a full-length word
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_id != fpid_pkg::OP_ILLEGAL |->
      op_id <= fpid_pkg::OP_FMV_D_X && length_bytes == fpid_pkg::LEN_WORD)
    else $error("operation number out of range");

endmodule

bind fp_instruction_decoder fpid_checker u_fpid_checker (.*);

### tb/testbench.sv
// Self-checking testbench for fp_instruction_decoder: a directed table, then
// random instruction words, checked beat by beat against a local decoder.
// Depends on fpid_pkg and the fp_instruction_decoder RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PER_PH = 450;
  localparam int MAX_PRINTED   = 100;

  // Encoding pieces not in the package
  localparam logic [1:0]                LEN32_MARK   = 2'b11;
  localparam logic [4:0]                LONG_MARK    = 5'h1F;
  localparam logic [1:0]                FMT_S        = 2'b00;
  localparam logic [1:0]                FMT_D        = 2'b01;
  localparam logic [1:0]                FMT_H        = 2'b10;
  localparam logic [1:0]                FMT_Q        = 2'b11;
  localparam logic [2:0]                RM_RNE       = 3'd0;
  localparam logic [2:0]                RM_RTZ       = 3'd1;
  localparam logic [2:0]                RM_RMM       = 3'd4;
  localparam logic [2:0]                RM_DYN       = 3'd7;
  localparam logic [2:0]                F3_CLASS     = 3'd1;
  localparam logic [2:0]                F3_SGNJX     = 3'd2;
  localparam logic [2:0]                F3_BAD       = 3'd3;
  localparam logic [4:0]                RS2_LU       = 5'd3;
  localparam logic [fpid_pkg::OpcW-1:0] OPC_CUSTOM_0 = 7'h0B;
  localparam logic [fpid_pkg::F7W-1:0]  F7_UNUSED    = 7'h7F;

  typedef struct packed {
    logic [fpid_pkg::WordW-1:0] word;
    fpid_pkg::fpid_result_t     result;
  } pending_beat_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [fpid_pkg::WordW-1:0]    instr_word;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          status;
  logic [fpid_pkg::OpIdW-1:0]    op_id;
  logic [fpid_pkg::RegW-1:0]     dest_reg;
  logic [fpid_pkg::RegW-1:0]     src1_reg;
  logic [fpid_pkg::RegW-1:0]     src2_reg;
  logic [fpid_pkg::RegW-1:0]     src3_reg;
  logic [fpid_pkg::RmW-1:0]      round_mode;
  logic [fpid_pkg::LenW-1:0]     length_bytes;

  pending_beat_t                 decoded_q[$];
  logic [fpid_pkg::WordW-1:0]    dir_word[$];
  bit                            dir_typed[$];
  fpid_pkg::fpid_result_t        dir_result[$];

  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  fp_instruction_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .instr_word  (instr_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .op_id       (op_id),
    .dest_reg    (dest_reg),
    .src1_reg    (src1_reg),
    .src2_reg    (src2_reg),
    .src3_reg    (src3_reg),
    .round_mode  (round_mode),
    .length_bytes(length_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected decode of one instruction word
  function automatic fpid_pkg::fpid_result_t decode_fp_word(
      input logic [fpid_pkg::WordW-1:0] w);
    fpid_pkg::fpid_result_t      r;
    logic [fpid_pkg::OpcW-1:0]   opc;
    logic [fpid_pkg::F7W-1:0]    f7;
    logic [fpid_pkg::RmW-1:0]    f3;
    logic [fpid_pkg::RegW-1:0]   rs2;
    logic [fpid_pkg::OpIdW-1:0]  f3_ext;
    logic [fpid_pkg::OpIdW-1:0]  rs2_ext;
    r = '0;
    r.status = fpid_pkg::STAT_LOCAL;
    r.op_id = fpid_pkg::OP_ILLEGAL;
    r.length_bytes = fpid_pkg::LEN_WORD;
    opc = w[6:0];
    f7 = w[31:25];
    f3 = w[14:12];
    rs2 = w[24:20];
    f3_ext = {3'b000, f3};
    rs2_ext = {1'b0, rs2};
    if (w[1:0] != LEN32_MARK) begin
      // compressed: another decoder's job
      r.status = fpid_pkg::STAT_FOREIGN;
      r.length_bytes = fpid_pkg::LEN_SHORT;
    end else if (w[4:0] == LONG_MARK) begin
      r.length_bytes = fpid_pkg::LEN_SHORT;
    end else begin
      case (opc)
        fpid_pkg::OPC_LOAD, fpid_pkg::OPC_LOAD_FP, fpid_pkg::OPC_MISC_MEM,
        fpid_pkg::OPC_OP_IMM, fpid_pkg::OPC_AUIPC, fpid_pkg::OPC_OP_IMM_32,
        fpid_pkg::OPC_STORE, fpid_pkg::OPC_STORE_FP, fpid_pkg::OPC_AMO,
        fpid_pkg::OPC_OP, fpid_pkg::OPC_LUI, fpid_pkg::OPC_OP_32,
        fpid_pkg::OPC_BRANCH, fpid_pkg::OPC_JALR, fpid_pkg::OPC_JAL,
        fpid_pkg::OPC_SYSTEM: r.status = fpid_pkg::STAT_FOREIGN;
        default: begin
          r.dest_reg = w[11:7];
          r.src1_reg = w[19:15];
          r.src2_reg = rs2;
          if (opc == fpid_pkg::OPC_MADD || opc == fpid_pkg::OPC_MSUB ||
              opc == fpid_pkg::OPC_NMSUB || opc == fpid_pkg::OPC_NMADD) begin
            // two formats per fused opcode, opcode bits 3:2 pick the group
            if (f7[1:0] == FMT_S || f7[1:0] == FMT_D) begin
              r.op_id = fpid_pkg::OP_FMADD_S + {3'b000, opc[3:2], f7[0]};
              r.src3_reg = f7[6:2];
            end
          end else if (opc == fpid_pkg::OPC_OP_FP) begin
            case (f7)
              fpid_pkg::F7_FADD_S:    r.op_id = fpid_pkg::OP_FADD_S;
              fpid_pkg::F7_FADD_D:    r.op_id = fpid_pkg::OP_FADD_D;
              fpid_pkg::F7_FSUB_S:    r.op_id = fpid_pkg::OP_FSUB_S;
              fpid_pkg::F7_FSUB_D:    r.op_id = fpid_pkg::OP_FSUB_D;
              fpid_pkg::F7_FMUL_S:    r.op_id = fpid_pkg::OP_FMUL_S;
              fpid_pkg::F7_FMUL_D:    r.op_id = fpid_pkg::OP_FMUL_D;
              fpid_pkg::F7_FDIV_S:    r.op_id = fpid_pkg::OP_FDIV_S;
              fpid_pkg::F7_FDIV_D:    r.op_id = fpid_pkg::OP_FDIV_D;
              fpid_pkg::F7_FSQRT_S:   if (rs2 == 0) r.op_id = fpid_pkg::OP_FSQRT_S;
              fpid_pkg::F7_FSQRT_D:   if (rs2 == 0) r.op_id = fpid_pkg::OP_FSQRT_D;
              fpid_pkg::F7_FSGNJ_S:   if (f3 <= 2) r.op_id = fpid_pkg::OP_FSGNJ_S + f3_ext;
              fpid_pkg::F7_FSGNJ_D:   if (f3 <= 2) r.op_id = fpid_pkg::OP_FSGNJ_D + f3_ext;
              fpid_pkg::F7_FMINMAX_S: if (f3 <= 1) r.op_id = fpid_pkg::OP_FMIN_S + f3_ext;
              fpid_pkg::F7_FMINMAX_D: if (f3 <= 1) r.op_id = fpid_pkg::OP_FMIN_D + f3_ext;
              fpid_pkg::F7_FCVT_S_D:  if (rs2 == 1) r.op_id = fpid_pkg::OP_FCVT_S_D;
              fpid_pkg::F7_FCVT_D_S:  if (rs2 == 0) r.op_id = fpid_pkg::OP_FCVT_D_S;
              fpid_pkg::F7_FCVT_X_S:  if (rs2 <= 3) r.op_id = fpid_pkg::OP_FCVT_W_S + rs2_ext;
              fpid_pkg::F7_FCVT_X_D:  if (rs2 <= 3) r.op_id = fpid_pkg::OP_FCVT_W_D + rs2_ext;
              fpid_pkg::F7_FMVCLS_S: begin
                if (rs2 == 0 && f3 <= 1) r.op_id = fpid_pkg::OP_FMV_X_W + f3_ext;
              end
              fpid_pkg::F7_FMVCLS_D: begin
                if (rs2 == 0 && f3 <= 1) r.op_id = fpid_pkg::OP_FMV_X_D + f3_ext;
              end
              fpid_pkg::F7_FCMP_S:    if (f3 <= 2) r.op_id = fpid_pkg::OP_FLE_S + f3_ext;
              fpid_pkg::F7_FCMP_D:    if (f3 <= 2) r.op_id = fpid_pkg::OP_FLE_D + f3_ext;
              fpid_pkg::F7_FCVT_S_X:  if (rs2 <= 3) r.op_id = fpid_pkg::OP_FCVT_S_W + rs2_ext;
              fpid_pkg::F7_FCVT_D_X:  if (rs2 <= 3) r.op_id = fpid_pkg::OP_FCVT_D_W + rs2_ext;
              fpid_pkg::F7_FMV_W_X: begin
                if (rs2 == 0 && f3 == 0) r.op_id = fpid_pkg::OP_FMV_W_X;
              end
              fpid_pkg::F7_FMV_D_X: begin
                if (rs2 == 0 && f3 == 0) r.op_id = fpid_pkg::OP_FMV_D_X;
              end
              default:      r.op_id = fpid_pkg::OP_ILLEGAL;
            endcase
          end
          // funct3 passes through on every decoded form, even when it picks the op
          if (r.op_id != fpid_pkg::OP_ILLEGAL) r.round_mode = f3;
        end
      endcase
    end
    return r;
  endfunction

  function automatic fpid_pkg::fpid_result_t make_result(
      input logic st, input logic [fpid_pkg::OpIdW-1:0] op,
      input logic [fpid_pkg::RegW-1:0] rd, input logic [fpid_pkg::RegW-1:0] rs1,
      input logic [fpid_pkg::RegW-1:0] rs2, input logic [fpid_pkg::RegW-1:0] rs3,
      input logic [fpid_pkg::RmW-1:0] rm, input logic [fpid_pkg::LenW-1:0] len);
    fpid_pkg::fpid_result_t r;
    r.status = st;
    r.op_id = op;
    r.dest_reg = rd;
    r.src1_reg = rs1;
    r.src2_reg = rs2;
    r.src3_reg = rs3;
    r.round_mode = rm;
    r.length_bytes = len;
    return r;
  endfunction

  // Random word: mostly well-formed FP forms, plus broken ones and noise
  function automatic logic [fpid_pkg::WordW-1:0] random_fp_word();
    logic [fpid_pkg::WordW-1:0] w;
    int               sel;
    int               kind;
    w = $urandom();
    sel = $urandom_range(0, 99);
    kind = $urandom_range(0, 26);
    if (sel < 60) begin
      if (kind == 0) begin
        case ($urandom_range(0, 3))
          0:       w[6:0] = fpid_pkg::OPC_MADD;
          1:       w[6:0] = fpid_pkg::OPC_MSUB;
          2:       w[6:0] = fpid_pkg::OPC_NMSUB;
          default: w[6:0] = fpid_pkg::OPC_NMADD;
        endcase
        w[26:25] = ($urandom_range(0, 1) == 0) ? FMT_S : FMT_D;
      end else begin
        w[6:0] = fpid_pkg::OPC_OP_FP;
        case (kind)
          1:  w[31:25] = fpid_pkg::F7_FADD_S;     2:  w[31:25] = fpid_pkg::F7_FADD_D;
          3:  w[31:25] = fpid_pkg::F7_FSUB_S;     4:  w[31:25] = fpid_pkg::F7_FSUB_D;
          5:  w[31:25] = fpid_pkg::F7_FMUL_S;     6:  w[31:25] = fpid_pkg::F7_FMUL_D;
          7:  w[31:25] = fpid_pkg::F7_FDIV_S;     8:  w[31:25] = fpid_pkg::F7_FDIV_D;
          9:  w[31:25] = fpid_pkg::F7_FSQRT_S;    10: w[31:25] = fpid_pkg::F7_FSQRT_D;
          11: w[31:25] = fpid_pkg::F7_FSGNJ_S;    12: w[31:25] = fpid_pkg::F7_FSGNJ_D;
          13: w[31:25] = fpid_pkg::F7_FMINMAX_S;  14: w[31:25] = fpid_pkg::F7_FMINMAX_D;
          15: w[31:25] = fpid_pkg::F7_FCVT_S_D;   16: w[31:25] = fpid_pkg::F7_FCVT_D_S;
          17: w[31:25] = fpid_pkg::F7_FCVT_X_S;   18: w[31:25] = fpid_pkg::F7_FCVT_X_D;
          19: w[31:25] = fpid_pkg::F7_FMVCLS_S;   20: w[31:25] = fpid_pkg::F7_FMVCLS_D;
          21: w[31:25] = fpid_pkg::F7_FCMP_S;     22: w[31:25] = fpid_pkg::F7_FCMP_D;
          23: w[31:25] = fpid_pkg::F7_FCVT_S_X;   24: w[31:25] = fpid_pkg::F7_FCVT_D_X;
          25: w[31:25] = fpid_pkg::F7_FMV_W_X;    default: w[31:25] = fpid_pkg::F7_FMV_D_X;
        endcase
        // pin rs2 / funct3 sub-fields to a legal choice
        case (w[31:25])
          fpid_pkg::F7_FSQRT_S, fpid_pkg::F7_FSQRT_D, fpid_pkg::F7_FCVT_D_S:
            w[24:20] = '0;
          fpid_pkg::F7_FCVT_S_D: w[24:20] = 5'd1;
          fpid_pkg::F7_FSGNJ_S, fpid_pkg::F7_FSGNJ_D,
          fpid_pkg::F7_FCMP_S, fpid_pkg::F7_FCMP_D:
            w[14:12] = 3'($urandom_range(0, 2));
          fpid_pkg::F7_FMINMAX_S, fpid_pkg::F7_FMINMAX_D:
            w[14:12] = 3'($urandom_range(0, 1));
          fpid_pkg::F7_FCVT_X_S, fpid_pkg::F7_FCVT_X_D,
          fpid_pkg::F7_FCVT_S_X, fpid_pkg::F7_FCVT_D_X:
            w[24:20] = 5'($urandom_range(0, 3));
          fpid_pkg::F7_FMVCLS_S, fpid_pkg::F7_FMVCLS_D: begin
            w[24:20] = '0;
            w[14:12] = 3'($urandom_range(0, 1));
          end
          fpid_pkg::F7_FMV_W_X, fpid_pkg::F7_FMV_D_X: begin
            w[24:20] = '0;
            w[14:12] = '0;
          end
          default: ;
        endcase
      end
    end else if (sel < 75) begin
      // FP opcode with random upper bits: mostly malformed forms
      case (kind % 5)
        0:       w[6:0] = fpid_pkg::OPC_MADD;
        1:       w[6:0] = fpid_pkg::OPC_MSUB;
        2:       w[6:0] = fpid_pkg::OPC_NMSUB;
        3:       w[6:0] = fpid_pkg::OPC_NMADD;
        default: w[6:0] = fpid_pkg::OPC_OP_FP;
      endcase
    end else if (sel < 85) begin
      case (kind % 16)
        0:  w[6:0] = fpid_pkg::OPC_LOAD;     1:  w[6:0] = fpid_pkg::OPC_LOAD_FP;
        2:  w[6:0] = fpid_pkg::OPC_MISC_MEM; 3:  w[6:0] = fpid_pkg::OPC_OP_IMM;
        4:  w[6:0] = fpid_pkg::OPC_AUIPC;    5:  w[6:0] = fpid_pkg::OPC_OP_IMM_32;
        6:  w[6:0] = fpid_pkg::OPC_STORE;    7:  w[6:0] = fpid_pkg::OPC_STORE_FP;
        8:  w[6:0] = fpid_pkg::OPC_AMO;      9:  w[6:0] = fpid_pkg::OPC_OP;
        10: w[6:0] = fpid_pkg::OPC_LUI;      11: w[6:0] = fpid_pkg::OPC_OP_32;
        12: w[6:0] = fpid_pkg::OPC_BRANCH;   13: w[6:0] = fpid_pkg::OPC_JALR;
        14: w[6:0] = fpid_pkg::OPC_JAL;      default: w[6:0] = fpid_pkg::OPC_SYSTEM;
      endcase
    end else if (sel < 92) begin
      if (kind[0]) w[1:0] = 2'($urandom_range(0, 2));
      else w[4:0] = LONG_MARK;
    end
    return w;
  endfunction

  task automatic add_row(input logic [fpid_pkg::WordW-1:0] w, input bit typed,
                         input fpid_pkg::fpid_result_t r);
    dir_word.push_back(w);
    dir_typed.push_back(typed);
    dir_result.push_back(r);
  endtask

  // Present one beat, hold it until taken, then log what should come out
  task automatic send_word(input logic [fpid_pkg::WordW-1:0] w,
                           input fpid_pkg::fpid_result_t exp_result);
    pending_beat_t beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instr_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beat.word = w;
    beat.result = exp_result;
    decoded_q.push_back(beat);
  endtask

  task automatic report_mismatch(input string field, input logic [fpid_pkg::WordW-1:0] w,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("ERROR %0t: %s word=%08h got=%0h exp=%0h", $time, field, w, got, want);
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each output beat with the oldest expectation
  always @(posedge clk) begin : check_results
    pending_beat_t head;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected beat, op_id", '0, 32'(op_id), '0);
      end else begin
        head = decoded_q.pop_front();
        if (status !== head.result.status)
          report_mismatch("status", head.word, 32'(status), 32'(head.result.status));
        if (op_id !== head.result.op_id)
          report_mismatch("op_id", head.word, 32'(op_id), 32'(head.result.op_id));
        if (dest_reg !== head.result.dest_reg)
          report_mismatch("dest_reg", head.word, 32'(dest_reg),
                          32'(head.result.dest_reg));
        if (src1_reg !== head.result.src1_reg)
          report_mismatch("src1_reg", head.word, 32'(src1_reg),
                          32'(head.result.src1_reg));
        if (src2_reg !== head.result.src2_reg)
          report_mismatch("src2_reg", head.word, 32'(src2_reg),
                          32'(head.result.src2_reg));
        if (src3_reg !== head.result.src3_reg)
          report_mismatch("src3_reg", head.word, 32'(src3_reg),
                          32'(head.result.src3_reg));
        if (round_mode !== head.result.round_mode)
          report_mismatch("round_mode", head.word, 32'(round_mode),
                          32'(head.result.round_mode));
        if (length_bytes !== head.result.length_bytes)
          report_mismatch("length_bytes", head.word, 32'(length_bytes),
                          32'(head.result.length_bytes));
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d pending", quiet_cycles, decoded_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [fpid_pkg::WordW-1:0] w;
    rst = 1'b1;
    in_valid = 1'b0;
    instr_word = '0;

    // Directed table: typed expectations for the plain cases, predictor for the rest
    // compressed forms
    add_row(32'h0000_0000, 1'b1, make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
            0, 0, 0, 0, 0, fpid_pkg::LEN_SHORT));
    add_row(32'hFFFF_FFFE, 1'b1, make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
            0, 0, 0, 0, 0, fpid_pkg::LEN_SHORT));
    add_row(32'hFFFF_FFFD, 1'b1, make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
            0, 0, 0, 0, 0, fpid_pkg::LEN_SHORT));
    // long forms are illegal here
    add_row(32'hFFFF_FFFF, 1'b1, make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
            0, 0, 0, 0, 0, fpid_pkg::LEN_SHORT));
    add_row({27'h0, LONG_MARK}, 1'b1, make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
            0, 0, 0, 0, 0, fpid_pkg::LEN_SHORT));
    // foreign opcodes
    add_row({25'h1FF_FFFF, fpid_pkg::OPC_SYSTEM}, 1'b1,
            make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
                        0, 0, 0, 0, 0, fpid_pkg::LEN_WORD));
    add_row({25'h000_0000, fpid_pkg::OPC_LOAD}, 1'b1,
            make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
                        0, 0, 0, 0, 0, fpid_pkg::LEN_WORD));
    add_row({25'h155_5555, fpid_pkg::OPC_JAL}, 1'b1,
            make_result(fpid_pkg::STAT_FOREIGN, fpid_pkg::OP_ILLEGAL,
                        0, 0, 0, 0, 0, fpid_pkg::LEN_WORD));
    // unknown opcode, fused with half and quad formats
    add_row({25'h1FF_FFFF, OPC_CUSTOM_0}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        31, 31, 31, 0, 0, fpid_pkg::LEN_WORD));
    add_row({5'd31, FMT_H, 5'd31, 5'd31, RM_DYN, 5'd31, fpid_pkg::OPC_MADD}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        31, 31, 31, 0, 0, fpid_pkg::LEN_WORD));
    add_row({5'd0, FMT_Q, 5'd0, 5'd0, RM_RNE, 5'd0, fpid_pkg::OPC_NMADD}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        0, 0, 0, 0, 0, fpid_pkg::LEN_WORD));
    // fused forms at field extremes
    add_row({5'd31, FMT_S, 5'd31, 5'd31, RM_DYN, 5'd31, fpid_pkg::OPC_MADD}, 1'b0, '0);
    add_row({5'd0, FMT_D, 5'd0, 5'd0, RM_RNE, 5'd0, fpid_pkg::OPC_NMADD}, 1'b0, '0);
    add_row({5'd17, FMT_D, 5'd10, 5'd21, RM_RTZ, 5'd6, fpid_pkg::OPC_MSUB}, 1'b0, '0);
    add_row({5'd6, FMT_S, 5'd21, 5'd10, RM_RMM, 5'd17, fpid_pkg::OPC_NMSUB}, 1'b0, '0);
    // OP-FP, legal and with bad sub-fields
    add_row({fpid_pkg::F7_FADD_S, 5'd31, 5'd31, RM_DYN, 5'd31, fpid_pkg::OPC_OP_FP},
            1'b0, '0);
    add_row({fpid_pkg::F7_FMV_D_X, 5'd0, 5'd9, RM_RNE, 5'd3, fpid_pkg::OPC_OP_FP},
            1'b0, '0);
    add_row({fpid_pkg::F7_FSQRT_S, 5'd1, 5'd4, RM_RNE, 5'd5, fpid_pkg::OPC_OP_FP}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        5, 4, 1, 0, 0, fpid_pkg::LEN_WORD));
    add_row({fpid_pkg::F7_FSGNJ_S, 5'd2, 5'd3, F3_BAD, 5'd4, fpid_pkg::OPC_OP_FP}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        4, 3, 2, 0, 0, fpid_pkg::LEN_WORD));
    add_row({fpid_pkg::F7_FSGNJ_D, 5'd12, 5'd13, F3_SGNJX, 5'd14, fpid_pkg::OPC_OP_FP},
            1'b0, '0);
    add_row({fpid_pkg::F7_FCVT_X_D, RS2_LU, 5'd7, RM_RTZ, 5'd8, fpid_pkg::OPC_OP_FP},
            1'b0, '0);
    add_row({fpid_pkg::F7_FCVT_S_D, 5'd0, 5'd7, RM_RNE, 5'd8, fpid_pkg::OPC_OP_FP}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        8, 7, 0, 0, 0, fpid_pkg::LEN_WORD));
    add_row({fpid_pkg::F7_FMVCLS_D, 5'd0, 5'd30, F3_CLASS, 5'd1, fpid_pkg::OPC_OP_FP},
            1'b0, '0);
    add_row({fpid_pkg::F7_FMV_W_X, 5'd0, 5'd2, F3_CLASS, 5'd3, fpid_pkg::OPC_OP_FP}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        3, 2, 0, 0, 0, fpid_pkg::LEN_WORD));
    add_row({F7_UNUSED, 5'd31, 5'd31, RM_DYN, 5'd31, fpid_pkg::OPC_OP_FP}, 1'b1,
            make_result(fpid_pkg::STAT_LOCAL, fpid_pkg::OP_ILLEGAL,
                        31, 31, 31, 0, 0, fpid_pkg::LEN_WORD));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Three idle profiles: slow receiver, slow sender, full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          stall_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          stall_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      if (ph == 0) begin
        for (int i = 0; i < dir_word.size(); i++)
          send_word(dir_word[i], dir_typed[i] ? dir_result[i] : decode_fp_word(dir_word[i]));
      end
      repeat (RANDOM_PER_PH) begin
        w = random_fp_word();
        send_word(w, decode_fp_word(w));
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep watching to catch stray beats
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
